// ===== design/smds_pkg.sv =====
// shared types and codes for the stack machine data stack
package smds_pkg;

  // fixed field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOP_W    = 32;
  localparam int unsigned IN_W     = 32;

  // request modes (code seven is unused and acts as a no-op)
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_DROP  = 3'd1,
    MODE_SWAP  = 3'd2,
    MODE_DUP   = 3'd3,
    MODE_OVER  = 3'd4,
    MODE_CLEAR = 3'd5,
    MODE_DEPTH = 3'd6
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_IN,
    OP_PUSH_TOP,
    OP_PUSH_SEC,
    OP_PUSH_CNT,
    OP_DROP,
    OP_SWAP,
    OP_CLEAR
  } op_e;

  // command from controller to datapath
  typedef struct packed {
    logic    valid;     // request accepted this cycle
    op_e     op;
    status_e status;
    logic    load_sec;  // refill second word from memory read data
  } cmd_t;

  // occupancy flags from datapath to controller
  typedef struct packed {
    logic empty;
    logic below_two;
    logic at_least_three;
    logic full;
  } flags_t;

endpackage

// ===== design/stack_machine_data_stack_core.sv =====
// top level of the stack machine data stack
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  request  | start, busy (accept when  | mode_i, push_word_i
//           | start && !busy)           |
//  result   | done_o (one-cycle strobe) | status_o, top_word_o, stack_depth_o
//
// the result strobe comes in the cycle after the request is accepted
// a drop that starts from three or more words holds busy while the second cached
// word is refilled from the spill memory read port
// every other request allows a new request in the very next cycle
// reset clears the element count; memory contents need no clearing
// results cannot be stalled by the receiver
module stack_machine_data_stack_core #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned CountW      = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [smds_pkg::MODE_W-1:0]   mode_i,
  input  logic [smds_pkg::IN_W-1:0]     push_word_i,
  output logic                          done_o,
  output logic [smds_pkg::STATUS_W-1:0] status_o,
  output logic [smds_pkg::TOP_W-1:0]    top_word_o,
  output logic [CountW-1:0]             stack_depth_o
);
  import smds_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // request decode and sequencing
  smds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .mode_i  (mode_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy    (busy),
    .done_o  (done_o)
  );

  // stack storage and result registers
  smds_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH),
    .CountW      (CountW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .push_word_i   (push_word_i),
    .flags_o       (flags),
    .status_o      (status_o),
    .top_word_o    (top_word_o),
    .stack_depth_o (stack_depth_o)
  );

endmodule

// ===== design/smds_ctrl.sv =====
// controller: decodes requests, checks occupancy and sequences the refill cycle
module smds_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [smds_pkg::MODE_W-1:0]   mode_i,
  input  smds_pkg::flags_t              flags_i,
  output smds_pkg::cmd_t                cmd_o,
  output logic                          busy,
  output logic                          done_o
);
  import smds_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;
  logic   refill;

  assign accept = start && (state_q == S_IDLE);

  // decode the request against current occupancy
  always_comb begin
    cmd_o          = '0;
    cmd_o.valid    = accept;
    cmd_o.op       = OP_NONE;
    cmd_o.status   = ST_OK;
    cmd_o.load_sec = (state_q == S_FILL);
    refill         = 1'b0;
    unique case (mode_i)
      MODE_PUSH: begin
        if (flags_i.full) cmd_o.status = ST_OVER;
        else cmd_o.op = OP_PUSH_IN;
      end
      MODE_DROP: begin
        if (flags_i.empty) cmd_o.status = ST_UNDER;
        else begin
          cmd_o.op = OP_DROP;
          refill   = flags_i.at_least_three;
        end
      end
      MODE_SWAP: begin
        if (flags_i.below_two) cmd_o.status = ST_UNDER;
        else cmd_o.op = OP_SWAP;
      end
      MODE_DUP: begin
        if (flags_i.empty) cmd_o.status = ST_UNDER;
        else if (flags_i.full) cmd_o.status = ST_OVER;
        else cmd_o.op = OP_PUSH_TOP;
      end
      MODE_OVER: begin
        if (flags_i.below_two) cmd_o.status = ST_UNDER;
        else if (flags_i.full) cmd_o.status = ST_OVER;
        else cmd_o.op = OP_PUSH_SEC;
      end
      MODE_CLEAR: cmd_o.op = OP_CLEAR;
      MODE_DEPTH: begin
        if (flags_i.full) cmd_o.status = ST_OVER;
        else cmd_o.op = OP_PUSH_CNT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    done_d  = accept;
    unique case (state_q)
      S_IDLE: if (accept && refill) state_d = S_FILL;
      S_FILL: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and strobe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q == S_FILL);
  assign done_o = done_q;

  // refill follows an accepted request directly
  a_fill_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $past(start && !busy))
    else $error("refill cycle without a preceding request");

  // refill lasts a single cycle
  a_fill_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("refill cycle longer than one clock");

  // one result strobe per accepted request
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result strobe without an accepted request");

endmodule

// ===== design/smds_dpath.sv =====
// datapath: top two words in registers, deeper words in a spill memory
module smds_dpath #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned CountW      = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smds_pkg::cmd_t                cmd_i,
  input  logic [smds_pkg::IN_W-1:0]     push_word_i,
  output smds_pkg::flags_t              flags_o,
  output logic [smds_pkg::STATUS_W-1:0] status_o,
  output logic [smds_pkg::TOP_W-1:0]    top_word_o,
  output logic [CountW-1:0]             stack_depth_o
);
  import smds_pkg::*;

  localparam int unsigned AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned WideA  = (WORD_WIDTH > IN_W) ? WORD_WIDTH : IN_W;
  localparam int unsigned WideB  = (WideA > TOP_W) ? WideA : TOP_W;
  localparam int unsigned WideW  = (WideB > CountW) ? WideB : CountW;

  logic [WORD_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rd_q;
  logic [WORD_WIDTH-1:0] top_q, top_d;
  logic [WORD_WIDTH-1:0] sec_q, sec_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [CountW-1:0]     spill_cnt, fill_cnt;
  logic [AddrW-1:0]      wr_addr, rd_addr;
  logic                  wr_en;
  logic [WORD_WIDTH-1:0] push_val;
  logic [WideW-1:0]      in_wide, cnt_wide, top_wide;

  logic [STATUS_W-1:0]   status_q;
  logic [TOP_W-1:0]      top_word_q;
  logic [CountW-1:0]     depth_q;

  // occupancy flags
  assign flags_o.empty          = (count_q == '0);
  assign flags_o.below_two      = (count_q < CountW'(2));
  assign flags_o.at_least_three = (count_q >= CountW'(3));
  assign flags_o.full           = (count_q >= CountW'(STACK_DEPTH));

  // spill slot below the cached pair, and the slot that refills it after a drop
  assign spill_cnt = count_q - CountW'(2);
  assign fill_cnt  = count_q - CountW'(3);
  assign wr_addr   = spill_cnt[AddrW-1:0];
  assign rd_addr   = fill_cnt[AddrW-1:0];

  // word widths adjusted to the stack word
  assign in_wide  = WideW'(push_word_i);
  assign cnt_wide = WideW'(count_q);

  always_comb begin
    unique case (cmd_i.op)
      OP_PUSH_TOP: push_val = top_q;
      OP_PUSH_SEC: push_val = sec_q;
      OP_PUSH_CNT: push_val = cnt_wide[WORD_WIDTH-1:0];
      default:     push_val = in_wide[WORD_WIDTH-1:0];
    endcase
  end

  // next state of the cached pair and the count
  always_comb begin
    top_d   = top_q;
    sec_d   = sec_q;
    count_d = count_q;
    wr_en   = 1'b0;
    if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_PUSH_IN, OP_PUSH_TOP, OP_PUSH_SEC, OP_PUSH_CNT: begin
          wr_en   = !flags_o.below_two;
          sec_d   = top_q;
          top_d   = push_val;
          count_d = count_q + CountW'(1);
        end
        OP_DROP: begin
          top_d   = sec_q;
          count_d = count_q - CountW'(1);
        end
        OP_SWAP: begin
          top_d = sec_q;
          sec_d = top_q;
        end
        OP_CLEAR: count_d = '0;
        default: count_d = count_q;
      endcase
    end else if (cmd_i.load_sec) begin
      sec_d = rd_q;
    end
  end

  assign top_wide = WideW'(top_d);

  // spill memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= sec_q;
    rd_q <= mem_q[rd_addr];
  end

  // cached top words
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
  end

  // element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid) begin
      status_q   <= cmd_i.status;
      top_word_q <= (count_d != '0) ? top_wide[TOP_W-1:0] : '0;
      depth_q    <= count_d;
    end
  end

  assign status_o      = status_q;
  assign top_word_o    = top_word_q;
  assign stack_depth_o = depth_q;

  // count never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(STACK_DEPTH))
    else $error("element count beyond stack depth");

  // an error leaves the count as it was
  a_error_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.status != ST_OK) |=> count_q == $past(count_q))
    else $error("count changed on an error");

  // refill only when a second word remains
  a_refill_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_sec |-> count_q >= CountW'(2))
    else $error("refill with fewer than two words held");

endmodule

// ===== sim/tb.sv =====
// testbench for the stack machine data stack core
`timescale 1ns / 1ps

module tb;
  import smds_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int unsigned RANDOM_REQS = 1530;

  // one stack result as the block should report it
  typedef struct {
    logic [MODE_W-1:0] mode;
    status_e           status;
    logic [TOP_W-1:0]  top;
    logic [CNT_W-1:0]  depth;
  } stack_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode_i;
  logic [IN_W-1:0]     push_word_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [TOP_W-1:0]    top_word_o;
  logic [CNT_W-1:0]    stack_depth_o;

  // shadow copy of the stack
  logic [31:0]      shadow_store [DEPTH];
  int unsigned      shadow_count;
  stack_result_t    pending_q[$];

  // bookkeeping
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned under_count;
  int unsigned over_count;
  int unsigned peak_depth;
  int unsigned mismatch_count;
  int unsigned error_count;
  int unsigned burst_left;
  bit          gaps_on;

  stack_machine_data_stack_core #(
    .STACK_DEPTH(DEPTH),
    .WORD_WIDTH (32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .push_word_i  (push_word_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .top_word_o   (top_word_o),
    .stack_depth_o(stack_depth_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: timeout with %0d results outstanding", pending_q.size());
    $display("tb: errors");
    $finish;
  end

  // apply one stack operation to the shadow copy and return the expected result
  function automatic stack_result_t apply_stack_op(input logic [MODE_W-1:0] mode,
                                                   input logic [31:0] word);
    stack_result_t res;
    logic [31:0]   tmp;
    int unsigned   n;
    bit            full;
    n          = shadow_count;
    full       = (n >= DEPTH);
    res.mode   = mode;
    res.status = ST_OK;
    case (mode)
      MODE_PUSH: begin
        if (full) res.status = ST_OVER;
        else begin
          shadow_store[n] = word;
          shadow_count    = n + 1;
        end
      end
      MODE_DROP: begin
        if (n < 1) res.status = ST_UNDER;
        else shadow_count = n - 1;
      end
      MODE_SWAP: begin
        if (n < 2) res.status = ST_UNDER;
        else begin
          tmp                 = shadow_store[n - 1];
          shadow_store[n - 1] = shadow_store[n - 2];
          shadow_store[n - 2] = tmp;
        end
      end
      MODE_DUP: begin
        if (n < 1) res.status = ST_UNDER;
        else if (full) res.status = ST_OVER;
        else begin
          shadow_store[n] = shadow_store[n - 1];
          shadow_count    = n + 1;
        end
      end
      MODE_OVER: begin
        if (n < 2) res.status = ST_UNDER;
        else if (full) res.status = ST_OVER;
        else begin
          shadow_store[n] = shadow_store[n - 2];
          shadow_count    = n + 1;
        end
      end
      MODE_CLEAR: shadow_count = 0;
      MODE_DEPTH: begin
        if (full) res.status = ST_OVER;
        else begin
          shadow_store[n] = 32'(n);
          shadow_count    = n + 1;
        end
      end
      default: ;
    endcase
    res.top   = (shadow_count > 0) ? shadow_store[shadow_count - 1] : '0;
    res.depth = CNT_W'(shadow_count);
    return res;
  endfunction

  // word patterns weighted toward the edges
  function automatic logic [31:0] pick_word();
    logic [31:0] one_hot;
    one_hot = 32'd1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // present one request, wait for acceptance, then idle per the burst pattern
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [31:0] word);
    stack_result_t res;
    int unsigned   gap;
    start       <= 1'b1;
    mode_i      <= mode;
    push_word_i <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = apply_stack_op(mode, word);
    pending_q.push_back(res);
    sent_count++;
    if (shadow_count > peak_depth) peak_depth = shadow_count;
    // bursts of random length separated by random gaps
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    stack_result_t exp;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        error_count++;
        if (mismatch_count < 10)
          $display("tb: unexpected result status %0d top %h depth %0d",
                   status_o, top_word_o, stack_depth_o);
        mismatch_count++;
      end else begin
        exp = pending_q.pop_front();
        checked_count++;
        if (exp.status == ST_UNDER) under_count++;
        if (exp.status == ST_OVER) over_count++;
        if (status_o !== exp.status || top_word_o !== exp.top ||
            stack_depth_o !== exp.depth) begin
          error_count++;
          if (mismatch_count < 10)
            $display("tb: mode %0d mismatch: status %0d/%0d top %h/%h depth %0d/%0d",
                     exp.mode, status_o, exp.status, top_word_o, exp.top,
                     stack_depth_o, exp.depth);
          mismatch_count++;
        end
      end
    end
  end

  // errors on an empty stack, every mode on a small stack, the unused code
  task automatic test_directed();
    send_request(MODE_DROP, 32'h1234_5678);
    send_request(MODE_SWAP, '0);
    send_request(MODE_DUP, '0);
    send_request(MODE_OVER, '0);
    send_request(MODE_CLEAR, '1);
    send_request(MODE_UNUSED, '1);
    send_request(MODE_DEPTH, '0);
    send_request(MODE_PUSH, 32'hFFFF_FFFF);
    send_request(MODE_PUSH, 32'h0000_0000);
    send_request(MODE_SWAP, '1);
    send_request(MODE_OVER, '0);
    send_request(MODE_DUP, '0);
    send_request(MODE_DEPTH, '0);
    send_request(MODE_PUSH, 32'hA5A5_5A5A);
    send_request(MODE_UNUSED, 32'h5A5A_A5A5);
    send_request(MODE_DROP, '0);
    send_request(MODE_DROP, '0);
    send_request(MODE_CLEAR, '0);
    send_request(MODE_PUSH, 32'h8000_0001);
    send_request(MODE_SWAP, '0);
    send_request(MODE_OVER, '0);
    send_request(MODE_DROP, '0);
    send_request(MODE_DROP, '0);
  endtask

  // fill to the top, hit overflow with every growing mode, then drain
  task automatic test_full_stack();
    send_request(MODE_CLEAR, '0);
    while (shadow_count < DEPTH) begin
      case ($urandom_range(0, 3))
        0:       send_request(MODE_DEPTH, pick_word());
        1:       send_request(shadow_count > 0 ? MODE_DUP : MODE_PUSH, pick_word());
        default: send_request(MODE_PUSH, pick_word());
      endcase
    end
    send_request(MODE_PUSH, pick_word());
    send_request(MODE_DUP, '0);
    send_request(MODE_OVER, '0);
    send_request(MODE_DEPTH, '0);
    send_request(MODE_SWAP, '0);
    send_request(MODE_UNUSED, '0);
    send_request(MODE_DROP, '0);
    send_request(MODE_OVER, '0);
    send_request(MODE_DEPTH, '0);
    while (shadow_count > 0) send_request(MODE_DROP, pick_word());
    send_request(MODE_DROP, '0);
  endtask

  // back-to-back drops and refills on a deep stack, no idle cycles
  task automatic test_drop_refill();
    int unsigned i;
    gaps_on = 1'b0;
    for (i = 0; i < 12; i++) send_request(MODE_PUSH, pick_word());
    for (i = 0; i < 40; i++) begin
      case ($urandom_range(0, 5))
        0:       send_request(MODE_SWAP, '0);
        1:       send_request(MODE_DUP, '0);
        2:       send_request(MODE_OVER, '0);
        default: send_request(MODE_DROP, '0);
      endcase
      if (shadow_count < 4) send_request(MODE_PUSH, pick_word());
    end
    gaps_on = 1'b1;
  endtask

  // random mix that sweeps the stack between empty and full
  task automatic test_random_mix();
    int unsigned       i;
    int unsigned       r;
    bit                growing;
    logic [MODE_W-1:0] mode;
    growing = 1'b1;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (growing && shadow_count == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && shadow_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 45)      mode = MODE_PUSH;
        else if (r < 55) mode = MODE_DUP;
        else if (r < 63) mode = MODE_OVER;
        else if (r < 70) mode = MODE_DEPTH;
        else if (r < 80) mode = MODE_SWAP;
        else if (r < 97) mode = MODE_DROP;
        else if (r < 98) mode = MODE_CLEAR;
        else             mode = MODE_UNUSED;
      end else begin
        if (r < 55)      mode = MODE_DROP;
        else if (r < 65) mode = MODE_SWAP;
        else if (r < 73) mode = MODE_PUSH;
        else if (r < 79) mode = MODE_DUP;
        else if (r < 84) mode = MODE_OVER;
        else if (r < 89) mode = MODE_DEPTH;
        else if (r < 91) mode = MODE_CLEAR;
        else if (r < 93) mode = MODE_UNUSED;
        else             mode = MODE_DROP;
      end
      send_request(mode, pick_word());
    end
  endtask

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = MODE_PUSH;
    push_word_i    = '0;
    shadow_count   = 0;
    sent_count     = 0;
    checked_count  = 0;
    under_count    = 0;
    over_count     = 0;
    peak_depth     = 0;
    mismatch_count = 0;
    error_count    = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_stack();
    test_drop_refill();
    test_random_mix();

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("tb: %0d requests sent, %0d results checked, peak depth %0d",
             sent_count, checked_count, peak_depth);
    $display("tb: %0d underflow and %0d overflow results, %0d mismatches",
             under_count, over_count, mismatch_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
